[sv/integer_to_padded_digit_string_unit_defines.svh]
// assertion macros for the integer to padded digit string unit
// used by the modules that carry concurrent assertions; no other dependencies
`ifndef INTEGER_TO_PADDED_DIGIT_STRING_UNIT_DEFINES_SVH
`define INTEGER_TO_PADDED_DIGIT_STRING_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define ITPD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("itpd assertion failed");

// next-cycle implication, disabled during reset
`define ITPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("itpd assertion failed");

`endif

[sv/itpd_pkg.sv]
// shared types and constants of the integer to padded digit string unit
// no dependencies; imported by the input interface and all modules
package itpd_pkg;

    // input magnitude and digit store geometry
    localparam int BIN_BITS   = 32;
    localparam int NUM_DIGITS = 10;
    localparam int HEX_DIGITS = 8;
    localparam int DIG_W      = 4;
    localparam int IDX_W      = $clog2(NUM_DIGITS);
    localparam int BITCNT_W   = $clog2(BIN_BITS);
    localparam int PADW_W     = 6;

    // character codes
    localparam logic [7:0] C_CHAR_ZERO  = 8'h30;
    localparam logic [7:0] C_CHAR_SEVEN = 8'h37;
    localparam logic [7:0] C_CHAR_M     = 8'h4D;
    localparam logic [7:0] C_PAD_BYTE   = 8'hFF;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_COUNT,
        ST_PAD,
        ST_SIGN,
        ST_DIGIT
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic conv_step;
        logic count;
        logic emit_pad;
        logic emit_sign;
        logic emit_digit;
    } t_itpd_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic hex;
        logic neg;
        logic conv_last;
        logic pads_zero;
        logic dig_last;
        logic out_free;
    } t_itpd_sts;

endpackage

[sv/itpd_if.sv]
// valid/ready channel interfaces for number input and character output
// depends on itpd_pkg
interface itpd_in_if;
    import itpd_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [BIN_BITS-1:0] value;
    logic                     base_is_hex;
    logic [PADW_W-1:0]        pad_width;
    logic                     zero_pad;

    modport source (output valid, output value, output base_is_hex,
                    output pad_width, output zero_pad, input ready);
    modport sink   (input valid, input value, input base_is_hex,
                    input pad_width, input zero_pad, output ready);
endinterface

interface itpd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       last_char;

    modport source (output valid, output character, output last_char, input ready);
    modport sink   (input valid, input character, input last_char, output ready);
endinterface

[sv/itpd_ctrl.sv]
// controller state machine: sequences load, conversion, layout and emission
// depends on itpd_pkg
module itpd_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  itpd_pkg::t_itpd_sts   i_sts,
    output logic                  o_in_ready,
    output itpd_pkg::t_itpd_cmd   o_cmd
);
    import itpd_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_CONV;
            end
            ST_CONV: begin
                if (i_sts.hex || i_sts.conv_last) n_state = ST_COUNT;
            end
            ST_COUNT: begin
                n_state = ST_PAD;
            end
            ST_PAD: begin
                if (i_sts.pads_zero) n_state = i_sts.neg ? ST_SIGN : ST_DIGIT;
            end
            ST_SIGN: begin
                if (i_sts.out_free) n_state = ST_DIGIT;
            end
            ST_DIGIT: begin
                if (i_sts.out_free && i_sts.dig_last) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_CONV: begin
                o_cmd.conv_step = !i_sts.hex;
            end
            ST_COUNT: begin
                o_cmd.count = 1'b1;
            end
            ST_PAD: begin
                o_cmd.emit_pad = !i_sts.pads_zero && i_sts.out_free;
            end
            ST_SIGN: begin
                o_cmd.emit_sign = i_sts.out_free;
            end
            ST_DIGIT: begin
                o_cmd.emit_digit = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

[sv/itpd_datapath.sv]
// datapath: magnitude, binary to bcd shifter, digit store, layout counters
// and the output character register; depends on itpd_pkg and the defines header
module itpd_datapath #(
    parameter int MAX_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  itpd_pkg::t_itpd_cmd                 i_cmd,
    output itpd_pkg::t_itpd_sts                 o_sts,
    input  logic signed [itpd_pkg::BIN_BITS-1:0] i_value,
    input  logic                                i_base_is_hex,
    input  logic [itpd_pkg::PADW_W-1:0]         i_pad_width,
    input  logic                                i_zero_pad,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [7:0]                          o_character,
    output logic                                o_last_char
);
    import itpd_pkg::*;
    `include "integer_to_padded_digit_string_unit_defines.svh"

    localparam int W_CNT = $clog2(MAX_WIDTH + 1);

    logic [BIN_BITS-1:0] r_mag;
    logic [DIG_W-1:0]    r_digits [NUM_DIGITS];
    logic [BITCNT_W-1:0] r_bitcnt;
    logic                r_hex;
    logic                r_neg;
    logic                r_zero_pad;
    logic [W_CNT-1:0]    r_width;
    logic [W_CNT-1:0]    r_pads;
    logic [IDX_W-1:0]    r_dig_idx;
    logic                r_out_valid;
    logic [7:0]          r_out_char;
    logic                r_out_last;

    logic [BIN_BITS-1:0] w_mag_in;
    logic [DIG_W-1:0]    w_adj [NUM_DIGITS];
    logic [DIG_W-1:0]    w_shift [NUM_DIGITS];
    logic [IDX_W-1:0]    w_top;
    logic [W_CNT-1:0]    w_used;
    logic [DIG_W-1:0]    w_cur_dig;
    logic [7:0]          w_dig_char;
    logic                w_out_free;

    // magnitude of the two's complement input
    assign w_mag_in = i_value[BIN_BITS-1] ? (~i_value + BIN_BITS'(1)) : i_value;

    // one shift-add-3 step over all bcd digits
    always_comb begin
        for (int k = 0; k < NUM_DIGITS; k++) begin
            w_adj[k] = (r_digits[k] >= DIG_W'(5)) ? (r_digits[k] + DIG_W'(3)) : r_digits[k];
        end
        w_shift[0] = {w_adj[0][DIG_W-2:0], r_mag[BIN_BITS-1]};
        for (int k = 1; k < NUM_DIGITS; k++) begin
            w_shift[k] = {w_adj[k][DIG_W-2:0], w_adj[k-1][DIG_W-1]};
        end
    end

    // index of the highest nonzero digit, zero when all digits are zero
    always_comb begin
        w_top = '0;
        for (int k = 1; k < NUM_DIGITS; k++) begin
            if (r_digits[k] != '0) w_top = IDX_W'(k);
        end
        w_used = W_CNT'(w_top) + W_CNT'(1) + W_CNT'(r_neg);
    end

    // current digit as ascii, uppercase hex
    assign w_cur_dig  = r_digits[r_dig_idx];
    assign w_dig_char = (w_cur_dig < DIG_W'(10)) ? (C_CHAR_ZERO + 8'(w_cur_dig))
                                                 : (C_CHAR_SEVEN + 8'(w_cur_dig));

    assign w_out_free = !r_out_valid || i_out_ready;

    // load, conversion and layout registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_hex      <= i_base_is_hex;
            r_neg      <= i_value[BIN_BITS-1];
            r_zero_pad <= i_zero_pad;
            r_mag      <= w_mag_in;
            r_bitcnt   <= '0;
            r_width    <= (i_pad_width > PADW_W'(MAX_WIDTH)) ? W_CNT'(MAX_WIDTH)
                                                             : W_CNT'(i_pad_width);
            for (int k = 0; k < NUM_DIGITS; k++) begin
                if (i_base_is_hex && (k < HEX_DIGITS)) begin
                    r_digits[k] <= w_mag_in[k*DIG_W +: DIG_W];
                end else begin
                    r_digits[k] <= '0;
                end
            end
        end else if (i_cmd.conv_step) begin
            r_mag    <= {r_mag[BIN_BITS-2:0], 1'b0};
            r_bitcnt <= r_bitcnt + BITCNT_W'(1);
            for (int k = 0; k < NUM_DIGITS; k++) begin
                r_digits[k] <= w_shift[k];
            end
        end
        if (i_cmd.count) begin
            r_dig_idx <= w_top;
            r_pads    <= (r_width > w_used) ? (r_width - w_used) : '0;
        end else begin
            if (i_cmd.emit_pad)   r_pads    <= r_pads - W_CNT'(1);
            if (i_cmd.emit_digit) r_dig_idx <= r_dig_idx - IDX_W'(1);
        end
    end

    // output character register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_pad || i_cmd.emit_sign || i_cmd.emit_digit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.emit_pad) begin
            r_out_char <= r_zero_pad ? C_CHAR_ZERO : C_PAD_BYTE;
            r_out_last <= 1'b0;
        end else if (i_cmd.emit_sign) begin
            r_out_char <= C_CHAR_M;
            r_out_last <= 1'b0;
        end else if (i_cmd.emit_digit) begin
            r_out_char <= w_dig_char;
            r_out_last <= (r_dig_idx == '0);
        end
    end

    // status to controller
    assign o_sts.hex       = r_hex;
    assign o_sts.neg       = r_neg;
    assign o_sts.conv_last = (r_bitcnt == BITCNT_W'(BIN_BITS - 1));
    assign o_sts.pads_zero = (r_pads == '0);
    assign o_sts.dig_last  = (r_dig_idx == '0);
    assign o_sts.out_free  = w_out_free;

    assign o_out_valid = r_out_valid;
    assign o_character = r_out_char;
    assign o_last_char = r_out_last;

    // checks
    `ITPD_ASSERT_IMP(a_emit_needs_room, i_clk, i_rst_n,
        i_cmd.emit_pad || i_cmd.emit_sign || i_cmd.emit_digit, w_out_free)
    `ITPD_ASSERT_NEXT(a_last_on_final_digit, i_clk, i_rst_n,
        i_cmd.emit_digit && (r_dig_idx == '0), r_out_valid && r_out_last)
    `ITPD_ASSERT_NEXT(a_hex_digit_range, i_clk, i_rst_n,
        i_cmd.count && r_hex, r_dig_idx < IDX_W'(HEX_DIGITS))

endmodule

[sv/integer_to_padded_digit_string_unit.sv]
// Formats one signed 32-bit number per input beat as a left-padded ASCII string, one
// character per output beat with last_char on the final one. A new number is taken only
// when the unit is idle; the last character of the previous number may still wait in the
// output register. Decimal numbers pass a load step, the shift-add-3 binary to bcd
// converter (one input bit a cycle), a layout step, then the pad, sign and digit
// characters, each emitted only when the output register is free. Hex numbers pass the
// converter state without shifting. Pad width above MAX_WIDTH is saturated to MAX_WIDTH.
// depends on itpd_pkg, itpd_if, itpd_ctrl and itpd_datapath
module integer_to_padded_digit_string_unit #(
    parameter int MAX_WIDTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    itpd_in_if.sink    i_in,
    itpd_out_if.source o_out
);
    import itpd_pkg::*;

    t_itpd_cmd w_cmd;
    t_itpd_sts w_sts;
    logic      w_in_ready;

    // controller
    itpd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_sts      (w_sts),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    // datapath
    itpd_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_value       (i_in.value),
        .i_base_is_hex (i_in.base_is_hex),
        .i_pad_width   (i_in.pad_width),
        .i_zero_pad    (i_in.zero_pad),
        .o_out_valid   (o_out.valid),
        .i_out_ready   (o_out.ready),
        .o_character   (o_out.character),
        .o_last_char   (o_out.last_char)
    );

    assign i_in.ready = w_in_ready;

endmodule
